@@ rtl/wgc_pkg.sv @@
// ----------------------------------------------------------------------------
// wgc_pkg
// shared types, constants and the arctangent table of the go-to-goal controller
// ----------------------------------------------------------------------------
package wgc_pkg;

  // ring of targets and cordic depth
  localparam int TARGET_COUNT      = 3;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_TABLE_LEN   = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > ANGLE_TABLE_LEN) ?
                                     ANGLE_TABLE_LEN : CORDIC_ITERATIONS;
  localparam int ITER_W            = $clog2(CORDIC_STEPS);
  localparam int IDX_W             = 2;

  // datapath widths
  localparam int XY_W        = 27;  // cordic x/y, signed, offset scaled by 2^8
  localparam int ZW          = 20;  // cordic angle, signed q16 radians
  localparam int MAG_W       = 26;  // non-negative cordic magnitude
  localparam int MUL_B_W     = 16;  // multiplier operand consumed digit by digit
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = MUL_B_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
  localparam int PROD_W      = MAG_W + MUL_B_W;

  localparam logic signed [ZW-1:0] HALF_PI_Q16  = 20'sd102944;
  localparam logic [MUL_B_W-1:0]   INV_GAIN_Q16 = 16'd39797;
  localparam int                   HEADING_MAX  = 25736;

  // input item kinds
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // register map
  localparam logic [1:0] CFG_ARRIVE_DIST = 2'd0;
  localparam logic [1:0] CFG_FAR_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_GAIN_FAR    = 2'd2;
  localparam logic [1:0] CFG_GAIN_NEAR   = 2'd3;

  typedef struct packed {
    logic                   done;
    logic [MAG_W-1:0]       mag;
    logic signed [ZW-1:0]   ang;
  } cordic_res_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   prod;
  } mul_res_t;

  // atan(2^-i) in q16 radians, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = 20'sd51472;
      5'd1:    a = 20'sd30386;
      5'd2:    a = 20'sd16055;
      5'd3:    a = 20'sd8150;
      5'd4:    a = 20'sd4091;
      5'd5:    a = 20'sd2047;
      5'd6:    a = 20'sd1024;
      5'd7:    a = 20'sd512;
      5'd8:    a = 20'sd256;
      5'd9:    a = 20'sd128;
      5'd10:   a = 20'sd64;
      5'd11:   a = 20'sd32;
      5'd12:   a = 20'sd16;
      5'd13:   a = 20'sd8;
      5'd14:   a = 20'sd4;
      5'd15:   a = 20'sd2;
      5'd16:   a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/wgc_cordic.sv @@
// ----------------------------------------------------------------------------
// wgc_cordic
// iterated vectoring cordic: magnitude and bearing of the offset, one step a cycle
// ----------------------------------------------------------------------------
module wgc_cordic (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [15:0]       off_x,
  input  logic signed [15:0]       off_y,
  output wgc_pkg::cordic_res_t     res
);

  logic signed [wgc_pkg::XY_W-1:0] xs, ys, x0, y0;
  logic signed [wgc_pkg::XY_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [wgc_pkg::ZW-1:0]   z0, z_r, z_nxt, ang;
  logic [wgc_pkg::ITER_W-1:0]      it_r;
  logic                            run_r, done_r, zero_r;

  // offset scaled by 2^8, folded into the right half plane
  always_comb begin
    xs = {{(wgc_pkg::XY_W-24){off_x[15]}}, off_x, 8'h00};
    ys = {{(wgc_pkg::XY_W-24){off_y[15]}}, off_y, 8'h00};
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (off_x[15]) begin
      if (!off_y[15]) begin
        x0 = ys;
        y0 = -xs;
        z0 = wgc_pkg::HALF_PI_Q16;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -wgc_pkg::HALF_PI_Q16;
      end
    end
  end

  // one micro-rotation, arithmetic shifts round toward minus infinity
  always_comb begin
    dx  = y_r >>> it_r;
    dy  = x_r >>> it_r;
    ang = wgc_pkg::atan_q16(5'(it_r));
    if (!y_r[wgc_pkg::XY_W-1]) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + ang;
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        it_r   <= '0;
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
        zero_r <= (off_x == 16'sd0) && (off_y == 16'sd0);
      end else if (run_r) begin
        x_r  <= x_nxt;
        y_r  <= y_nxt;
        z_r  <= z_nxt;
        it_r <= it_r + wgc_pkg::ITER_W'(1);
        if (it_r == wgc_pkg::ITER_W'(wgc_pkg::CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // zero offset gives zero length and zero bearing
  assign res.done = done_r;
  assign res.mag  = (zero_r || x_r[wgc_pkg::XY_W-1]) ? '0 : x_r[wgc_pkg::MAG_W-1:0];
  assign res.ang  = zero_r ? '0 : z_r;

endmodule

@@ rtl/wgc_dsmul.sv @@
// ----------------------------------------------------------------------------
// wgc_dsmul
// digit-serial multiplier: one 4-bit digit of b per cycle, low digits shift out
// ----------------------------------------------------------------------------
module wgc_dsmul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wgc_pkg::MAG_W-1:0]     a,
  input  logic [wgc_pkg::MUL_B_W-1:0]   b,
  output wgc_pkg::mul_res_t             res
);

  localparam int SUM_W = wgc_pkg::MAG_W + wgc_pkg::DIGIT_W;

  logic [wgc_pkg::MAG_W-1:0]       a_r, hi_r;
  logic [wgc_pkg::MUL_B_W-1:0]     b_r, lo_r;
  logic [wgc_pkg::DIGIT_CNT_W-1:0] cnt_r;
  logic                            run_r, done_r;
  logic [SUM_W-1:0]                part, sum;

  // running high part never exceeds a, so the sum fits a plus one digit
  always_comb begin
    part = SUM_W'(a_r) * SUM_W'(b_r[wgc_pkg::DIGIT_W-1:0]);
    sum  = SUM_W'(hi_r) + part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        a_r   <= a;
        b_r   <= b;
        hi_r  <= '0;
        lo_r  <= '0;
      end else if (run_r) begin
        hi_r  <= sum[SUM_W-1:wgc_pkg::DIGIT_W];
        lo_r  <= {sum[wgc_pkg::DIGIT_W-1:0], lo_r[wgc_pkg::MUL_B_W-1:wgc_pkg::DIGIT_W]};
        b_r   <= b_r >> wgc_pkg::DIGIT_W;
        cnt_r <= cnt_r + wgc_pkg::DIGIT_CNT_W'(1);
        if (cnt_r == wgc_pkg::DIGIT_CNT_W'(wgc_pkg::NUM_DIGITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.prod = {hi_r, lo_r};

endmodule

@@ rtl/waypoint_go_to_goal_controller.sv @@
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller
// proportional go-to-goal controller over a ring of targets
// ----------------------------------------------------------------------------
// Each measure transfer carries the robot position and the offset to the
// current target (signed q8.8). The block returns the absolute goal, the
// offset length from an iterated cordic, the bearing in q3.13 radians, a
// speed command (length times near or far gain, rounded, saturated) and the
// target index, which advances modulo the target count when the length falls
// below the switch threshold. A manual transfer only advances the index and
// returns zeros elsewhere. One item is in work at a time. A measure item
// passes the cordic unit, which runs one micro-rotation per cycle, and
// then the 4-bit digit-serial multiplier twice, once for the length
// scaling and once for the speed product. A manual item skips both
// units. The result sits in an output register, so the next item is
// accepted while an earlier result waits to be taken.
// ----------------------------------------------------------------------------
module waypoint_go_to_goal_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos_x[15:0], pos_y[31:16], off_x[47:32], off_y[63:48]
  input  logic        in_tuser,   // cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // goal_x[16:0], goal_y[33:17], distance[49:34],
                                  // heading[65:50], speed[81:66], target_index[83:82],
                                  // switched[84], zero fill[87:85]
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_DIST,
    S_GAIN,
    S_SPEED,
    S_DONE
  } state_t;

  localparam int HW = wgc_pkg::ZW - 2;  // rounded heading before clamp
  localparam logic signed [HW-1:0] HEAD_HI = HW'(wgc_pkg::HEADING_MAX);
  localparam logic signed [HW-1:0] HEAD_LO = HW'(-wgc_pkg::HEADING_MAX);

  state_t state_r;

  // configuration registers
  logic [15:0] thr_r, far_limit_r;
  logic [9:0]  gain_far_r, gain_near_r;

  // item registers
  logic signed [16:0]         goal_x_r, goal_y_r;
  logic [15:0]                dist_r, speed_r;
  logic signed [15:0]         head_r;
  logic                       sw_r;
  logic [wgc_pkg::IDX_W-1:0]  target_r, target_adv;

  // result register
  logic        out_tvalid_r;
  logic [87:0] out_tdata_r;

  // unit handshakes
  wgc_pkg::cordic_res_t         cres;
  wgc_pkg::mul_res_t            mres;
  logic                         cordic_start, mul_start, in_xfer, out_free;
  logic [wgc_pkg::MAG_W-1:0]    mul_a;
  logic [wgc_pkg::MUL_B_W-1:0]  mul_b;
  logic [9:0]                   gain_sel;

  // rounding and saturation
  logic signed [wgc_pkg::ZW:0]  z_rnd;
  logic signed [HW-1:0]         head_full;
  logic signed [15:0]           head_q;
  logic [wgc_pkg::PROD_W:0]     dist_sum, sp_sum;
  logic [wgc_pkg::PROD_W-24:0]  dist_full;
  logic [wgc_pkg::PROD_W-8:0]   sp_full;
  logic [15:0]                  dist_q, speed_q;

  // -------------------------------------------------------------------------
  // handshakes
  // -------------------------------------------------------------------------
  assign in_tready    = (state_r == S_IDLE);
  assign in_xfer      = in_tvalid && in_tready;
  assign out_free     = !out_tvalid_r || out_tready;
  assign cordic_start = in_xfer && (in_tuser == wgc_pkg::CMD_MEASURE);
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;

  // -------------------------------------------------------------------------
  // configuration writes, wide data keeps only the register's low bits
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 16'd256;
      far_limit_r <= 16'd1024;
      gain_far_r  <= 10'd205;
      gain_near_r <= 10'd307;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wgc_pkg::CFG_ARRIVE_DIST: thr_r       <= cfg_wdata;
        wgc_pkg::CFG_FAR_LIMIT:   far_limit_r <= cfg_wdata;
        wgc_pkg::CFG_GAIN_FAR:    gain_far_r  <= cfg_wdata[9:0];
        wgc_pkg::CFG_GAIN_NEAR:   gain_near_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // cordic unit and shared multiplier
  // -------------------------------------------------------------------------
  wgc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .off_x (in_tdata[47:32]),
    .off_y (in_tdata[63:48]),
    .res   (cres)
  );

  // first pass: magnitude times 1/K, second pass: length times gain
  assign gain_sel  = (dist_r > far_limit_r) ? gain_far_r : gain_near_r;
  assign mul_start = ((state_r == S_CORDIC) && cres.done) || (state_r == S_GAIN);
  assign mul_a     = (state_r == S_GAIN) ? wgc_pkg::MAG_W'(dist_r) : cres.mag;
  assign mul_b     = (state_r == S_GAIN) ? wgc_pkg::MUL_B_W'(gain_sel)
                                         : wgc_pkg::INV_GAIN_Q16;

  wgc_dsmul u_dsmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mres)
  );

  // -------------------------------------------------------------------------
  // heading: round q16 angle to q3.13, clamp
  // -------------------------------------------------------------------------
  always_comb begin
    z_rnd     = (wgc_pkg::ZW + 1)'(cres.ang) + (wgc_pkg::ZW + 1)'(4);
    head_full = z_rnd[wgc_pkg::ZW:3];
    if (head_full > HEAD_HI) begin
      head_q = 16'(HEAD_HI);
    end else if (head_full < HEAD_LO) begin
      head_q = 16'(HEAD_LO);
    end else begin
      head_q = head_full[15:0];
    end
  end

  // -------------------------------------------------------------------------
  // distance: (x * 1/K + 2^23) >> 24, speed: (d * g + 128) >> 8, both saturate
  // -------------------------------------------------------------------------
  always_comb begin
    dist_sum  = (wgc_pkg::PROD_W + 1)'(mres.prod) + (wgc_pkg::PROD_W + 1)'(1 << 23);
    dist_full = dist_sum[wgc_pkg::PROD_W:24];
    dist_q    = (|dist_full[wgc_pkg::PROD_W-24:16]) ? 16'hFFFF : dist_full[15:0];
    sp_sum    = (wgc_pkg::PROD_W + 1)'(mres.prod) + (wgc_pkg::PROD_W + 1)'(128);
    sp_full   = sp_sum[wgc_pkg::PROD_W:8];
    speed_q   = (|sp_full[wgc_pkg::PROD_W-8:16]) ? 16'hFFFF : sp_full[15:0];
  end

  // index advance wraps at the end of the ring
  assign target_adv = (32'(target_r) >= wgc_pkg::TARGET_COUNT - 1) ? '0
                                                                    : target_r + 1'b1;

  // -------------------------------------------------------------------------
  // sequencer and result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result register loads when free, otherwise empties on a transfer
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            dist_r  <= '0;
            head_r  <= '0;
            speed_r <= '0;
            if (in_tuser == wgc_pkg::CMD_ADVANCE) begin
              // manual advance: zero payload, always switches
              goal_x_r <= '0;
              goal_y_r <= '0;
              sw_r     <= 1'b1;
              state_r  <= S_DONE;
            end else begin
              goal_x_r <= 17'($signed(in_tdata[15:0])) + 17'($signed(in_tdata[47:32]));
              goal_y_r <= 17'($signed(in_tdata[31:16])) + 17'($signed(in_tdata[63:48]));
              sw_r     <= 1'b0;
              state_r  <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (cres.done) begin
            head_r  <= head_q;
            state_r <= S_DIST;
          end
        end
        S_DIST: begin
          if (mres.done) begin
            dist_r  <= dist_q;
            state_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          // gain chosen from the stored length, multiplier started alongside
          sw_r    <= (dist_r < thr_r);
          state_r <= S_SPEED;
        end
        S_SPEED: begin
          if (mres.done) begin
            speed_r <= speed_q;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_tdata_r  <= {3'b000, sw_r, (sw_r ? target_adv : target_r),
                             speed_r, head_r, dist_r, goal_y_r, goal_x_r};
            if (sw_r) begin
              target_r <= target_adv;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // stored index always inside the ring
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(target_r) < wgc_pkg::TARGET_COUNT)
    else $error("target index outside the ring");

  // cordic finishes only while the sequencer waits for it
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cres.done |-> (state_r == S_CORDIC))
    else $error("cordic done outside its wait state");

  // multiplier finishes only during a multiply phase
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mres.done |-> (state_r == S_DIST || state_r == S_SPEED))
    else $error("multiplier done outside a multiply phase");

  // a switching result moves the index when the ring has more than one target
  a_switch_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free && sw_r && wgc_pkg::TARGET_COUNT > 1)
      |=> (target_r != $past(target_r)))
    else $error("switch did not advance the target index");
`endif

endmodule
